### rtl/blps_pkg.sv
package blps_pkg;

   localparam int NODE_LIMIT_DFLT = 64;
   localparam int BEAM_SIZE_DFLT  = 3;

   localparam int TYPE_W  = 2;
   localparam int NODE_W  = 6;
   localparam int LEN_W   = 7;
   localparam int BIDX_W  = 3;
   localparam int BCNT_W  = 4;

   localparam logic [LEN_W-1:0] NODE_COUNT_RST = 7'd64;

   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_EDGE  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_ONE   = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_ALL   = 2'd3;

   typedef struct packed {
      logic              capture;
      logic              clr_we;
      logic              edge_a;
      logic              edge_b;
      logic              init;
      logic              cand_clr;
      logic              beam_rd;
      logic              row_load;
      logic              scan;
      logic              commit;
      logic              best_clr;
      logic              walk_start;
      logic              walk_step;
      logic              out_rd;
      logic              err;
      logic [BIDX_W-1:0] i;
      logic [LEN_W-1:0]  j;
      logic [NODE_W-1:0] start;
      logic [LEN_W-1:0]  k;
   } blps_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [NODE_W-1:0] node_a;
      logic [LEN_W-1:0]  n;
      logic              edge_ok;
      logic              start_ok;
      logic [BCNT_W-1:0] beam_cnt;
      logic [LEN_W-1:0]  beam_len;
      logic [BCNT_W-1:0] cand_cnt;
      logic [LEN_W-1:0]  best_len;
      logic              walk_done;
   } blps_stat_type;

   typedef struct packed {
      logic [NODE_W-1:0] path_node;
      logic [NODE_W-1:0] position;
      logic [NODE_W-1:0] path_edges;
      logic              last;
      logic              status;
   } blps_rsp_type;

endpackage

### rtl/blps_req_if.sv
interface blps_req_if;
   import blps_pkg::*;
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;

   modport source (output valid, req_type, node_a, node_b, input ready);
   modport sink (input valid, req_type, node_a, node_b, output ready);
endinterface

### rtl/blps_rsp_if.sv
interface blps_rsp_if;
   import blps_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] path_node;
   logic [NODE_W-1:0] position;
   logic [NODE_W-1:0] path_edges;
   logic              last;
   logic              status;

   modport source (output valid, path_node, position, path_edges, last, status,
                   input ready);
   modport sink (input valid, path_node, position, path_edges, last, status,
                 output ready);
endinterface

### rtl/blps_ctrl.sv
module blps_ctrl import blps_pkg::*; #(
   parameter int NODE_LIMIT = NODE_LIMIT_DFLT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  blps_stat_type stat,
   output blps_cmd_type  cmd
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_CLEAR  = 5'd1;
   localparam logic [4:0] ST_DEC    = 5'd2;
   localparam logic [4:0] ST_EDGE_A = 5'd3;
   localparam logic [4:0] ST_EDGE_B = 5'd4;
   localparam logic [4:0] ST_ERR    = 5'd5;
   localparam logic [4:0] ST_INIT   = 5'd6;
   localparam logic [4:0] ST_CHK    = 5'd7;
   localparam logic [4:0] ST_BEAM   = 5'd8;
   localparam logic [4:0] ST_ROW    = 5'd9;
   localparam logic [4:0] ST_SCAN   = 5'd10;
   localparam logic [4:0] ST_DRAIN  = 5'd11;
   localparam logic [4:0] ST_COMMIT = 5'd12;
   localparam logic [4:0] ST_FIN    = 5'd13;
   localparam logic [4:0] ST_WALK0  = 5'd14;
   localparam logic [4:0] ST_WALK   = 5'd15;
   localparam logic [4:0] ST_NEXT   = 5'd16;
   localparam logic [4:0] ST_ORD    = 5'd17;
   localparam logic [4:0] ST_OSH    = 5'd18;

   localparam logic [LEN_W-1:0] CLR_END = LEN_W'(NODE_LIMIT - 1);

   logic [4:0]        state_ff, state_in;
   logic [BIDX_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic [NODE_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [1:0]        drain_ff, drain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         i_ff     <= '0;
         j_ff     <= '0;
         start_ff <= '0;
         k_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         start_ff <= start_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      start_in  = start_ff;
      k_in      = k_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.i     = i_ff;
      cmd.j     = j_ff;
      cmd.start = start_ff;
      cmd.k     = k_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DEC;
            end
         end
         ST_DEC: begin
            unique case (stat.req_type)
               REQ_CLEAR: begin
                  j_in     = '0;
                  state_in = ST_CLEAR;
               end
               REQ_EDGE: state_in = stat.edge_ok ? ST_EDGE_A : ST_IDLE;
               REQ_ONE: begin
                  if (stat.start_ok) begin
                     cmd.best_clr = 1'b1;
                     start_in     = stat.node_a;
                     state_in     = ST_INIT;
                  end else begin
                     state_in = ST_ERR;
                  end
               end
               default: begin
                  cmd.best_clr = 1'b1;
                  start_in     = '0;
                  state_in     = ST_INIT;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (j_ff == CLR_END) begin
               state_in = ST_IDLE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_EDGE_A: begin
            cmd.edge_a = 1'b1;
            state_in   = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            cmd.edge_b = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_ERR: begin
            cmd.err   = 1'b1;
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (stat.beam_len < stat.n) begin
               cmd.cand_clr = 1'b1;
               i_in         = '0;
               state_in     = ST_BEAM;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_BEAM: begin
            cmd.beam_rd = 1'b1;
            state_in    = ST_ROW;
         end
         ST_ROW: begin
            cmd.row_load = 1'b1;
            j_in         = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (j_ff == stat.n - 1'b1) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 2'd2) begin
               if ({1'b0, i_ff} + 1'b1 < stat.beam_cnt) begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_BEAM;
               end else begin
                  state_in = ST_COMMIT;
               end
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (stat.cand_cnt == '0) begin
               state_in = ST_FIN;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_CHK;
            end
         end
         ST_FIN: state_in = (stat.beam_len > stat.best_len) ? ST_WALK0 : ST_NEXT;
         ST_WALK0: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (stat.req_type == REQ_ALL && {1'b0, start_ff} + 1'b1 < stat.n) begin
               start_in = start_ff + 1'b1;
               state_in = ST_INIT;
            end else begin
               k_in     = '0;
               state_in = ST_ORD;
            end
         end
         ST_ORD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OSH;
         end
         ST_OSH: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (k_ff == stat.best_len - 1'b1) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/blps_dp.sv
module blps_dp import blps_pkg::*; #(
   parameter int NODE_LIMIT = NODE_LIMIT_DFLT,
   parameter int BEAM_SIZE  = BEAM_SIZE_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [NODE_W-1:0] node_a,
   input  logic [NODE_W-1:0] node_b,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  blps_cmd_type      cmd,
   output blps_stat_type     stat,
   output blps_rsp_type      rsp
);

   localparam int NIW  = $clog2(NODE_LIMIT);
   localparam int BIW  = (BEAM_SIZE > 1) ? $clog2(BEAM_SIZE) : 1;
   localparam int HW   = BIW + NIW;
   localparam int NGRP = (NODE_LIMIT + 7) / 8;
   localparam int GW   = NGRP * 8;
   localparam int SW   = $clog2(NODE_LIMIT + 1);

   logic [LEN_W-1:0]      node_count_ff;
   logic [TYPE_W-1:0]     type_ff;
   logic [NODE_W-1:0]     a_ff, b_ff;
   logic [LEN_W-1:0]      n_ff, act_n;
   logic [NODE_LIMIT-1:0] mask_ff, mask_in;

   logic [NODE_LIMIT-1:0] adj_mem [NODE_LIMIT];
   logic [NODE_LIMIT-1:0] adj_rd_ff;
   logic                  adj_we;
   logic [NIW-1:0]        adj_waddr, adj_raddr;
   logic [NODE_LIMIT-1:0] adj_wmask, adj_wdata;

   logic [NIW-1:0]        beam_end_ff [BEAM_SIZE];
   logic [NODE_LIMIT-1:0] beam_vis_ff [BEAM_SIZE];
   logic [BCNT_W-1:0]     beam_cnt_ff;
   logic [LEN_W-1:0]      beam_len_ff;
   logic [BIW-1:0]        bi;

   logic [NIW-1:0]        cand_node_ff [BEAM_SIZE];
   logic [BIW-1:0]        cand_par_ff [BEAM_SIZE];
   logic [SW-1:0]         cand_score_ff [BEAM_SIZE];
   logic [NODE_LIMIT-1:0] cand_vis_ff [BEAM_SIZE];
   logic [BCNT_W-1:0]     cand_cnt_ff;
   logic [NIW-1:0]        cand_node_in [BEAM_SIZE];
   logic [BIW-1:0]        cand_par_in [BEAM_SIZE];
   logic [SW-1:0]         cand_score_in [BEAM_SIZE];
   logic [NODE_LIMIT-1:0] cand_vis_in [BEAM_SIZE];
   logic [BCNT_W-1:0]     ins_pos;

   logic [NODE_LIMIT-1:0] open_ff;
   logic                  p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [NIW-1:0]        p1_node_ff, p2_node_ff, p3_node_ff;
   logic [NODE_LIMIT-1:0] p2_vis_ff, p3_vis_ff, vis_new;
   logic [3:0]            p2_grp_ff [NGRP];
   logic [3:0]            grp_in [NGRP];
   logic [SW-1:0]         p3_score_ff, score_in;
   logic [GW-1:0]         wpad;

   logic [BEAM_SIZE*HW-1:0] hist_mem [NODE_LIMIT];
   logic [BEAM_SIZE*HW-1:0] hist_rd_ff, hist_wdata;
   logic                    hist_we;
   logic [NIW-1:0]          hist_waddr, hist_raddr;
   logic [NIW-1:0]          walk_pos_ff;
   logic [BIW-1:0]          walk_slot_ff;
   logic [HW-1:0]           walk_entry;

   logic [NIW-1:0]   best_mem [NODE_LIMIT];
   logic [NIW-1:0]   best_rd_ff;
   logic [LEN_W-1:0] best_len_ff;

   assign bi = cmd.i[BIW-1:0];

   // active node count and request capture
   always_comb begin
      if (node_count_ff == '0) begin
         act_n = LEN_W'(1);
      end else if (node_count_ff > LEN_W'(NODE_LIMIT)) begin
         act_n = LEN_W'(NODE_LIMIT);
      end else begin
         act_n = node_count_ff;
      end
      for (int q = 0; q < NODE_LIMIT; q++) begin
         mask_in[q] = (LEN_W'(q) < act_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         a_ff    <= node_a;
         b_ff    <= node_b;
         n_ff    <= act_n;
         mask_ff <= mask_in;
      end
   end

   // adjacency matrix, bit-masked write port and one registered read port
   always_comb begin
      adj_we    = cmd.clr_we | cmd.edge_a | cmd.edge_b;
      adj_waddr = cmd.clr_we ? cmd.j[NIW-1:0] : (cmd.edge_a ? a_ff[NIW-1:0] : b_ff[NIW-1:0]);
      if (cmd.clr_we) begin
         adj_wmask = '1;
         adj_wdata = '0;
      end else begin
         adj_wmask = cmd.edge_a ? (NODE_LIMIT'(1) << b_ff[NIW-1:0])
                                : (NODE_LIMIT'(1) << a_ff[NIW-1:0]);
         adj_wdata = '1;
      end
      adj_raddr = cmd.beam_rd ? beam_end_ff[bi] : cmd.j[NIW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         for (int q = 0; q < NODE_LIMIT; q++) begin
            if (adj_wmask[q]) begin
               adj_mem[adj_waddr][q] <= adj_wdata[q];
            end
         end
      end
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   // candidate scoring pipeline
   always_comb begin
      vis_new = beam_vis_ff[bi] | (NODE_LIMIT'(1) << p1_node_ff);
      wpad    = GW'(adj_rd_ff & mask_ff & ~vis_new);
      for (int q = 0; q < NGRP; q++) begin
         grp_in[q] = '0;
         for (int b = 0; b < 8; b++) begin
            grp_in[q] = grp_in[q] + 4'(wpad[q*8+b]);
         end
      end
      score_in = '0;
      for (int q = 0; q < NGRP; q++) begin
         score_in = score_in + SW'(p2_grp_ff[q]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.scan & open_ff[cmd.j[NIW-1:0]];
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_load) begin
         open_ff <= adj_rd_ff & mask_ff & ~beam_vis_ff[bi];
      end
      p1_node_ff  <= cmd.j[NIW-1:0];
      p2_node_ff  <= p1_node_ff;
      p2_vis_ff   <= vis_new;
      p2_grp_ff   <= grp_in;
      p3_node_ff  <= p2_node_ff;
      p3_vis_ff   <= p2_vis_ff;
      p3_score_ff <= score_in;
   end

   // stable insertion into the sorted candidate list, earliest wins ties
   always_comb begin
      ins_pos = '0;
      for (int s = 0; s < BEAM_SIZE; s++) begin
         if (BCNT_W'(s) < cand_cnt_ff && cand_score_ff[s] <= p3_score_ff) begin
            ins_pos = ins_pos + 1'b1;
         end
      end
      for (int s = 0; s < BEAM_SIZE; s++) begin
         cand_node_in[s]  = cand_node_ff[s];
         cand_par_in[s]   = cand_par_ff[s];
         cand_score_in[s] = cand_score_ff[s];
         cand_vis_in[s]   = cand_vis_ff[s];
         if (BCNT_W'(s) == ins_pos) begin
            cand_node_in[s]  = p3_node_ff;
            cand_par_in[s]   = bi;
            cand_score_in[s] = p3_score_ff;
            cand_vis_in[s]   = p3_vis_ff;
         end else if (s > 0 && BCNT_W'(s) > ins_pos) begin
            cand_node_in[s]  = cand_node_ff[s-1];
            cand_par_in[s]   = cand_par_ff[s-1];
            cand_score_in[s] = cand_score_ff[s-1];
            cand_vis_in[s]   = cand_vis_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_cnt_ff <= '0;
      end else if (cmd.cand_clr) begin
         cand_cnt_ff <= '0;
      end else if (p3_valid_ff && cand_cnt_ff < BCNT_W'(BEAM_SIZE)) begin
         cand_cnt_ff <= cand_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_valid_ff && ins_pos < BCNT_W'(BEAM_SIZE)) begin
         cand_node_ff  <= cand_node_in;
         cand_par_ff   <= cand_par_in;
         cand_score_ff <= cand_score_in;
         cand_vis_ff   <= cand_vis_in;
      end
   end

   // beam state
   always_ff @(posedge clock) begin
      if (reset) begin
         beam_cnt_ff <= '0;
         beam_len_ff <= '0;
      end else if (cmd.init) begin
         beam_cnt_ff <= BCNT_W'(1);
         beam_len_ff <= LEN_W'(1);
      end else if (cmd.commit) begin
         beam_cnt_ff <= cand_cnt_ff;
         beam_len_ff <= beam_len_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         beam_end_ff[0] <= cmd.start[NIW-1:0];
         beam_vis_ff[0] <= NODE_LIMIT'(1) << cmd.start[NIW-1:0];
      end else if (cmd.commit) begin
         beam_end_ff <= cand_node_ff;
         beam_vis_ff <= cand_vis_ff;
      end
   end

   // path history, one row of parent and node per round
   always_comb begin
      hist_we    = cmd.init | cmd.commit;
      hist_waddr = cmd.init ? '0 : beam_len_ff[NIW-1:0];
      hist_wdata = '0;
      if (cmd.init) begin
         hist_wdata[HW-1:0] = {{BIW{1'b0}}, cmd.start[NIW-1:0]};
      end else begin
         for (int s = 0; s < BEAM_SIZE; s++) begin
            hist_wdata[s*HW +: HW] = {cand_par_ff[s], cand_node_ff[s]};
         end
      end
      hist_raddr = cmd.walk_start ? NIW'(beam_len_ff - 1'b1) : NIW'(walk_pos_ff - 1'b1);
      walk_entry = hist_rd_ff[walk_slot_ff*HW +: HW];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         walk_pos_ff  <= NIW'(beam_len_ff - 1'b1);
         walk_slot_ff <= '0;
      end else if (cmd.walk_step) begin
         walk_pos_ff  <= walk_pos_ff - 1'b1;
         walk_slot_ff <= walk_entry[HW-1:NIW];
      end
   end

   // best path store
   always_ff @(posedge clock) begin
      if (reset) begin
         best_len_ff <= '0;
      end else if (cmd.best_clr) begin
         best_len_ff <= '0;
      end else if (cmd.walk_start) begin
         best_len_ff <= beam_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         best_mem[walk_pos_ff] <= walk_entry[NIW-1:0];
      end
      if (cmd.out_rd) begin
         best_rd_ff <= best_mem[cmd.k[NIW-1:0]];
      end
   end

   always_comb begin
      stat.req_type  = type_ff;
      stat.node_a    = a_ff;
      stat.n         = n_ff;
      stat.edge_ok   = ({1'b0, a_ff} < n_ff) && ({1'b0, b_ff} < n_ff);
      stat.start_ok  = ({1'b0, a_ff} < n_ff);
      stat.beam_cnt  = beam_cnt_ff;
      stat.beam_len  = beam_len_ff;
      stat.cand_cnt  = cand_cnt_ff;
      stat.best_len  = best_len_ff;
      stat.walk_done = (walk_pos_ff == '0);
   end

   always_comb begin
      if (cmd.err) begin
         rsp.path_node  = '0;
         rsp.position   = '0;
         rsp.path_edges = '0;
         rsp.last       = 1'b1;
         rsp.status     = 1'b1;
      end else begin
         rsp.path_node  = NODE_W'(best_rd_ff);
         rsp.position   = cmd.k[NODE_W-1:0];
         rsp.path_edges = NODE_W'(best_len_ff - 1'b1);
         rsp.last       = (cmd.k == best_len_ff - 1'b1);
         rsp.status     = 1'b0;
      end
   end

endmodule

### rtl/beam_longest_path_search.sv
// Beam search for a long simple path over an undirected graph held as an adjacency
// bit matrix. A request clears the graph (the same clearing pass runs after reset,
// during which no request is taken), adds an edge, or runs a search from one start
// or from every start in turn. One request is handled at a time. Each search round
// scans the nodes of every beam path through the single read port of the adjacency
// memory, one node per cycle; a start that improves the best path adds a back-trace
// through the path history, and each result is then read out of the best-path
// memory. An out-of-range single start gives one result with status set.
module beam_longest_path_search import blps_pkg::*; #(
   parameter int NODE_LIMIT = NODE_LIMIT_DFLT,
   parameter int BEAM_SIZE  = BEAM_SIZE_DFLT
) (
   input  logic             clock,
   input  logic             reset,
   blps_req_if.sink         req_ch,
   blps_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   blps_cmd_type  cmd;
   blps_stat_type stat;
   blps_rsp_type  rsp;

   blps_ctrl #(
      .NODE_LIMIT(NODE_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   blps_dp #(
      .NODE_LIMIT(NODE_LIMIT),
      .BEAM_SIZE (BEAM_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_ch.req_type),
      .node_a      (req_ch.node_a),
      .node_b      (req_ch.node_b),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp         (rsp)
   );

   assign rsp_ch.path_node  = rsp.path_node;
   assign rsp_ch.position   = rsp.position;
   assign rsp_ch.path_edges = rsp.path_edges;
   assign rsp_ch.last       = rsp.last;
   assign rsp_ch.status     = rsp.status;

endmodule
